// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files that carry checks.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bps_pkg.sv =====
`default_nettype none

package bps_pkg;

    // Event codes carried on the action field.
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_OPEN   = 2'd1;
    localparam logic [1:0] ACT_CLOSE  = 2'd2;

    // Converter channels.
    localparam logic [1:0] CH_CONTROL   = 2'd0;
    localparam logic [1:0] CH_REFERENCE = 2'd1;
    localparam logic [1:0] CH_BEMF      = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SPIKE_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_CREEP_CORRECTION = 3'd1;
    localparam logic [2:0] REG_CONTROL_CENTER   = 3'd2;
    localparam logic [2:0] REG_VELOCITY_LIMIT   = 3'd3;
    localparam logic [2:0] REG_DRIVE_LIMIT      = 3'd4;

    // Configuration reset values.
    localparam logic [9:0]        RST_SPIKE_THRESHOLD  = 10'd20;
    localparam logic signed [6:0] RST_CREEP_CORRECTION = 7'sd5;
    localparam logic [9:0]        RST_CONTROL_CENTER   = 10'd512;
    localparam logic [9:0]        RST_VELOCITY_LIMIT   = 10'd511;
    localparam logic [7:0]        RST_DRIVE_LIMIT      = 8'd51;

    // Peak detector start value for the low peak.
    localparam logic [9:0] PEAK_MAX = 10'd1023;

    // Division by six: multiply by ceil(2^18 / 6) and keep the top bits.
    // Exact for magnitudes up to 2^15.
    localparam logic [16:0] RECIP_6     = 17'd43691;
    localparam int          RECIP_SHIFT = 18;

    // Operands of the drive computation.
    typedef struct packed {
        logic [9:0]         control_reading;
        logic [9:0]         control_center;
        logic [15:0]        position;
        logic signed [10:0] velocity;
        logic [9:0]         velocity_limit;
        logic [7:0]         drive_limit;
    } t_drive_in;

    // Directional duty levels.
    typedef struct packed {
        logic [7:0] cw;
        logic [7:0] ccw;
    } t_drive_out;

endpackage

`default_nettype wire

// ===== rtl/bps_drive_calc.sv =====
`default_nettype none

module bps_drive_calc
    import bps_pkg::*;
(
    input  var t_drive_in  i_op,
    output var t_drive_out o_drive
);

    logic signed [10:0] ctrl_diff;
    logic [15:0]        pos_err;
    logic [15:0]        err_mag;
    logic [32:0]        prod;
    logic [14:0]        quot;
    logic [10:0]        vset_mag;
    logic signed [11:0] vset;
    logic signed [12:0] vel_diff;
    logic signed [14:0] drive_raw;
    logic [13:0]        drive_mag;
    logic [13:0]        drive_sat;

    // Position error, wrapped to 16 bits like the position itself.
    assign ctrl_diff = $signed({1'b0, i_op.control_reading})
                     - $signed({1'b0, i_op.control_center});
    assign pos_err   = {ctrl_diff, 5'b00000} - i_op.position;

    // Truncating division by six on the magnitude.
    assign err_mag = pos_err[15] ? (16'd0 - pos_err) : pos_err;
    assign prod    = {17'd0, err_mag} * {16'd0, RECIP_6};
    assign quot    = prod[32:RECIP_SHIFT];

    // Symmetric clamp of the velocity setpoint, applied to the magnitude.
    always_comb begin
        if (quot > {5'd0, i_op.velocity_limit}) begin
            vset_mag = {1'b0, i_op.velocity_limit};
        end else begin
            vset_mag = quot[10:0];
        end
        vset = pos_err[15] ? -$signed({1'b0, vset_mag}) : $signed({1'b0, vset_mag});
    end

    // Velocity loop gain of four, then clamp and split by direction.
    assign vel_diff  = {vset[11], vset} - {{2{i_op.velocity[10]}}, i_op.velocity};
    assign drive_raw = {vel_diff, 2'b00};
    assign drive_mag = drive_raw[14] ? 14'(-drive_raw) : drive_raw[13:0];
    assign drive_sat = (drive_mag > {6'd0, i_op.drive_limit}) ?
                       {6'd0, i_op.drive_limit} : drive_mag;

    always_comb begin
        if (!drive_raw[14] && (drive_raw != 15'sd0)) begin
            o_drive.cw  = drive_sat[7:0];
            o_drive.ccw = 8'd0;
        end else begin
            o_drive.cw  = 8'd0;
            o_drive.ccw = drive_sat[7:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/backemf_position_servo.sv =====
`default_nettype none
// A transaction accepted into the input register moves on to the result register,
// which drives o_valid and holds the result until it is taken.
// Throughput: one transaction per cycle unless i_ready holds the result; the input register
// and the result register let a new item enter while the previous result is still waiting downstream.
// Reset: synchronous, active low; clears all servo state, the handshake valids,
// and loads the configuration registers with their defaults.

module backemf_position_servo
    import bps_pkg::*;
(
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    // Event channel
    input  var logic       i_valid,
    output var logic       o_ready,
    input  var logic [1:0] i_action,
    input  var logic [1:0] i_channel,
    input  var logic [9:0] i_sample,
    // Result channel
    output var logic       o_valid,
    input  var logic       i_ready,
    output var logic [1:0] o_next_channel,
    output var logic [7:0] o_drive_cw,
    output var logic [7:0] o_drive_ccw,
    output var logic       o_drive_updated,
    output var logic       o_window_rejected,
    // Configuration write port
    input  var logic       i_cfg_we,
    input  var logic [2:0] i_cfg_addr,
    input  var logic [9:0] i_cfg_wdata
);

    // Configuration registers
    logic [9:0]        r_spike_threshold;
    logic signed [6:0] r_creep_correction;
    logic [9:0]        r_control_center;
    logic [9:0]        r_velocity_limit;
    logic [7:0]        r_drive_limit;

    // Input register
    logic       r_in_vld;
    logic [1:0] r_action;
    logic [1:0] r_channel;
    logic [9:0] r_sample;

    // Servo state
    logic [9:0]         r_control, n_control;
    logic [9:0]         r_reference, n_reference;
    logic [9:0]         r_peak_high, n_peak_high;
    logic [9:0]         r_peak_low, n_peak_low;
    logic               r_window_open, n_window_open;
    logic signed [10:0] r_velocity, n_velocity;
    logic [15:0]        r_position, n_position;
    logic [1:0]         r_cur_chan, n_cur_chan;
    logic [7:0]         r_drive_cw, n_drive_cw;
    logic [7:0]         r_drive_ccw, n_drive_ccw;

    // Result register
    logic r_out_vld;
    logic r_updated, n_updated;
    logic r_rejected, n_rejected;

    logic               fire;
    logic signed [10:0] spread;
    logic [10:0]        peak_sum;
    logic signed [11:0] vel_new;
    logic signed [11:0] step;
    t_drive_in          drive_op;
    t_drive_out         drive_res;

    // The item in the input register moves to the result register when that is free.
    assign fire    = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || fire;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spike_threshold  <= RST_SPIKE_THRESHOLD;
            r_creep_correction <= RST_CREEP_CORRECTION;
            r_control_center   <= RST_CONTROL_CENTER;
            r_velocity_limit   <= RST_VELOCITY_LIMIT;
            r_drive_limit      <= RST_DRIVE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SPIKE_THRESHOLD:  r_spike_threshold  <= i_cfg_wdata;
                REG_CREEP_CORRECTION: r_creep_correction <= i_cfg_wdata[6:0];
                REG_CONTROL_CENTER:   r_control_center   <= i_cfg_wdata;
                REG_VELOCITY_LIMIT:   r_velocity_limit   <= i_cfg_wdata;
                REG_DRIVE_LIMIT:      r_drive_limit      <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Input register: valid is control, the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_action  <= i_action;
            r_channel <= i_channel;
            r_sample  <= i_sample;
        end
    end

    // Window measurements used at window close.
    assign spread   = $signed({1'b0, r_peak_high}) - $signed({1'b0, r_peak_low});
    assign peak_sum = {1'b0, r_peak_high} + {1'b0, r_peak_low};
    assign vel_new  = $signed({2'b00, peak_sum[10:1]}) - $signed({2'b00, r_reference});

    // Position integration increment.
    assign step = {r_velocity[10], r_velocity}
                - {{5{r_creep_correction[6]}}, r_creep_correction};

    // Drive computation sees the velocity of this step.
    assign drive_op = '{
        control_reading: r_control,
        control_center:  r_control_center,
        position:        r_position,
        velocity:        vel_new[10:0],
        velocity_limit:  r_velocity_limit,
        drive_limit:     r_drive_limit
    };

    bps_drive_calc u_drive_calc (
        .i_op    (drive_op),
        .o_drive (drive_res)
    );

    // Next-state logic for one event.
    always_comb begin
        n_control     = r_control;
        n_reference   = r_reference;
        n_peak_high   = r_peak_high;
        n_peak_low    = r_peak_low;
        n_window_open = r_window_open;
        n_velocity    = r_velocity;
        n_position    = r_position;
        n_cur_chan    = r_cur_chan;
        n_drive_cw    = r_drive_cw;
        n_drive_ccw   = r_drive_ccw;
        n_updated     = 1'b0;
        n_rejected    = 1'b0;
        case (r_action)
            ACT_SAMPLE: begin
                case (r_channel)
                    CH_CONTROL: begin
                        n_control = r_sample;
                        if (r_window_open) begin
                            n_cur_chan = CH_REFERENCE;
                        end
                    end
                    CH_REFERENCE: begin
                        n_reference = r_sample;
                        n_cur_chan  = CH_BEMF;
                        n_peak_low  = PEAK_MAX;
                        n_peak_high = 10'd0;
                    end
                    CH_BEMF: begin
                        if (r_sample < r_peak_low) begin
                            n_peak_low = r_sample;
                        end else if (r_sample > r_peak_high) begin
                            n_peak_high = r_sample;
                        end
                        if (!r_window_open) begin
                            n_cur_chan = CH_CONTROL;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_OPEN: begin
                n_window_open = 1'b1;
                n_position    = r_position + {{4{step[11]}}, step};
            end
            ACT_CLOSE: begin
                n_window_open = 1'b0;
                if (spread > $signed({1'b0, r_spike_threshold})) begin
                    n_rejected = 1'b1;
                end else begin
                    n_velocity  = vel_new[10:0];
                    n_drive_cw  = drive_res.cw;
                    n_drive_ccw = drive_res.ccw;
                    n_updated   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // State and result update; state only changes when the result register is free,
    // so the held levels double as the stalled result payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control     <= 10'd0;
            r_reference   <= 10'd0;
            r_peak_high   <= 10'd0;
            r_peak_low    <= 10'd0;
            r_window_open <= 1'b0;
            r_velocity    <= 11'sd0;
            r_position    <= 16'd0;
            r_cur_chan    <= CH_CONTROL;
            r_drive_cw    <= 8'd0;
            r_drive_ccw   <= 8'd0;
            r_updated     <= 1'b0;
            r_rejected    <= 1'b0;
        end else if (fire) begin
            r_control     <= n_control;
            r_reference   <= n_reference;
            r_peak_high   <= n_peak_high;
            r_peak_low    <= n_peak_low;
            r_window_open <= n_window_open;
            r_velocity    <= n_velocity;
            r_position    <= n_position;
            r_cur_chan    <= n_cur_chan;
            r_drive_cw    <= n_drive_cw;
            r_drive_ccw   <= n_drive_ccw;
            r_updated     <= n_updated;
            r_rejected    <= n_rejected;
        end
    end

    // Result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_next_channel    = r_cur_chan;
    assign o_drive_cw        = r_drive_cw;
    assign o_drive_ccw       = r_drive_ccw;
    assign o_drive_updated   = r_updated;
    assign o_window_rejected = r_rejected;

    // Checks on the servo logic.
    `include "assert_macros.svh"

    `CHK_SAME(a_one_direction, o_valid,
              (o_drive_cw == 8'd0) || (o_drive_ccw == 8'd0),
              "drive on both directions")
    `CHK_SAME(a_flags_exclusive, o_valid,
              !(o_drive_updated && o_window_rejected),
              "update and reject together")
    `CHK_NEXT(a_close_shuts_window, fire && (r_action == ACT_CLOSE),
              !r_window_open && o_valid,
              "window still open after close")
    `CHK_NEXT(a_drive_held, !fire,
              $stable(r_drive_cw) && $stable(r_drive_ccw),
              "drive changed without an event")

endmodule

`default_nettype wire
